// ----- rtl/core/crtrim_pkg.sv -----
// ============================================================================
// crtrim_pkg
// Shared constants for the content rectangle edge trimmer.
// ============================================================================
package crtrim_pkg;

    // fixed width of rectangle sizes and the slack register
    localparam int WH_BITS = 15;

    // coverage threshold: overlap * FRAC_DEN >= extent * FRAC_NUM
    localparam int FRAC_NUM = 17;
    localparam int FRAC_DEN = 20;

    localparam int DEF_MAX_PIECES = 16;
    localparam int DEF_COORD_BITS = 16;

    // rectangle roles
    localparam logic [1:0] FUNC_FRAME  = 2'd0;
    localparam logic [1:0] FUNC_WINDOW = 2'd1;
    localparam logic [1:0] FUNC_PIECE  = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // result kinds
    localparam logic KIND_CONTENT  = 1'b0;
    localparam logic KIND_OCCLUDER = 1'b1;

endpackage

// ----- rtl/core/content_rect_edge_trimmer_core.sv -----
// ============================================================================
// content_rect_edge_trimmer_core
// Trims a content rectangle against chrome pieces hugging its edges, then
// emits the content and every remaining occluder relative to it.
// ============================================================================
//
//  channel | dir | handshake          | beat payload
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_valid / s_ready  | func, rect x/y/width/height, set_end
//  m_      | out | m_valid / m_ready  | kind, x/y/width/height, last, dropped
//  cfg_    | in  | cfg_wr_en          | edge_slack (no read-back)
//
//  A set_end beat starts the sequencer: init, then read, overlap and decide
//  for each stored piece per trimming pass (passes repeat until one changes
//  nothing), then a step that queues the content, read, overlap and check for
//  each piece in the occluder scan, and a final step that hands out the last
//  result. The single overlap unit and the one-read piece memory take the pieces one at a time.
//  s_ready is low while a set is processed. A held result in the m_ register
//  only stalls the sequencer when the next result is ready to go.
//  Reset (aresetn, synchronous) clears control, counts, frame/window, slack.
// ============================================================================
module content_rect_edge_trimmer_core
    import crtrim_pkg::*;
#(
    parameter int MAX_PIECES = DEF_MAX_PIECES,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_wr_en,
    input  logic [WH_BITS-1:0]           cfg_wr_data,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic signed [COORD_BITS-1:0] s_rect_x,
    input  logic signed [COORD_BITS-1:0] s_rect_y,
    input  logic [WH_BITS-1:0]           s_rect_width,
    input  logic [WH_BITS-1:0]           s_rect_height,
    input  logic                         s_set_end,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_out_kind,
    output logic signed [COORD_BITS-1:0] m_out_x,
    output logic signed [COORD_BITS-1:0] m_out_y,
    output logic [WH_BITS-1:0]           m_out_width,
    output logic [WH_BITS-1:0]           m_out_height,
    output logic                         m_out_last,
    output logic                         m_pieces_dropped
);

    // internal coordinate width: room for right/bottom edges plus slack
    localparam int SW    = ((COORD_BITS > 16) ? COORD_BITS : 16) + 3;
    localparam int CW    = $clog2(MAX_PIECES + 1);
    localparam int IDX_W = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int PW    = WH_BITS + 5;

    typedef struct packed {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic [WH_BITS-1:0]   w;
        logic [WH_BITS-1:0]   h;
    } box_t;

    typedef struct packed {
        logic ne;
        box_t b;
    } ovl_t;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_INIT = 10'b0000000010,
        ST_RD   = 10'b0000000100,
        ST_OV   = 10'b0000001000,
        ST_DEC  = 10'b0000010000,
        ST_EST  = 10'b0000100000,
        ST_ERD  = 10'b0001000000,
        ST_EOV  = 10'b0010000000,
        ST_ECHK = 10'b0100000000,
        ST_FIN  = 10'b1000000000
    } state_t;

    function automatic logic signed [SW-1:0] ext_wh(input logic [WH_BITS-1:0] v);
        ext_wh = $signed({{(SW-WH_BITS){1'b0}}, v});
    endfunction

    // shared overlap unit: max of lefts, min of rights, same vertically
    function automatic ovl_t overlap(input box_t a, input box_t b);
        logic signed [SW-1:0] x0, y0, x1, y1, ax1, bx1, ay1, by1, dw, dh;
        ovl_t r;
        x0  = (a.x > b.x) ? a.x : b.x;
        y0  = (a.y > b.y) ? a.y : b.y;
        ax1 = a.x + ext_wh(a.w);
        bx1 = b.x + ext_wh(b.w);
        ay1 = a.y + ext_wh(a.h);
        by1 = b.y + ext_wh(b.h);
        x1  = (ax1 < bx1) ? ax1 : bx1;
        y1  = (ay1 < by1) ? ay1 : by1;
        dw  = x1 - x0;
        dh  = y1 - y0;
        r.ne  = (x1 > x0) && (y1 > y0);
        r.b.x = x0;
        r.b.y = y0;
        r.b.w = r.ne ? dw[WH_BITS-1:0] : '0;
        r.b.h = r.ne ? dh[WH_BITS-1:0] : '0;
        overlap = r;
    endfunction

    state_t state_reg, state_next;

    logic [WH_BITS-1:0] slack_reg;
    logic [CW-1:0]      cnt_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               ovf_reg;
    logic               changed_reg;
    box_t               frame_reg, window_reg, content_reg, rd_q_reg;
    ovl_t               ov_reg;
    box_t               piece_mem [MAX_PIECES];

    // pending result: held until the next one is known, so last is exact
    logic                         pend_kind_reg;
    logic signed [COORD_BITS-1:0] pend_x_reg, pend_y_reg;
    logic [WH_BITS-1:0]           pend_w_reg, pend_h_reg;

    logic                         m_valid_reg;
    logic                         out_kind_reg, out_last_reg, out_pd_reg;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic [WH_BITS-1:0]           out_w_reg, out_h_reg;

    logic accept, out_free, idx_last, push, fin_load;
    box_t in_box, ua, ub;
    ovl_t ov_c;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_last = ((CW'(idx_reg) + CW'(1)) == cnt_reg);
    assign push     = (state_reg == ST_ECHK) && ov_reg.ne && out_free;
    assign fin_load = (state_reg == ST_FIN) && out_free;

    assign in_box.x = {{(SW-COORD_BITS){s_rect_x[COORD_BITS-1]}}, s_rect_x};
    assign in_box.y = {{(SW-COORD_BITS){s_rect_y[COORD_BITS-1]}}, s_rect_y};
    assign in_box.w = s_rect_width;
    assign in_box.h = s_rect_height;

    assign ua   = (state_reg == ST_INIT) ? frame_reg  : content_reg;
    assign ub   = (state_reg == ST_INIT) ? window_reg : rd_q_reg;
    assign ov_c = overlap(ua, ub);

    // ---------------------------------------------------------------- trim
    logic [PW-1:0]        ovw_s, ovh_s, cw_s, ch_s;
    logic                 fw, fh, hit, upd;
    logic signed [SW-1:0] sl, c_bot, c_rgt, o_bot, o_rgt, p_bot, p_rgt, d;
    box_t                 nbox;

    always_comb begin
        ovw_s = PW'(ov_reg.b.w) * PW'(FRAC_DEN);
        ovh_s = PW'(ov_reg.b.h) * PW'(FRAC_DEN);
        cw_s  = PW'(content_reg.w) * PW'(FRAC_NUM);
        ch_s  = PW'(content_reg.h) * PW'(FRAC_NUM);
        fw    = ov_reg.ne && (ovw_s >= cw_s);
        fh    = ov_reg.ne && (ovh_s >= ch_s);
        sl    = ext_wh(slack_reg);
        c_bot = content_reg.y + ext_wh(content_reg.h);
        c_rgt = content_reg.x + ext_wh(content_reg.w);
        o_bot = ov_reg.b.y + ext_wh(ov_reg.b.h);
        o_rgt = ov_reg.b.x + ext_wh(ov_reg.b.w);
        p_bot = rd_q_reg.y + ext_wh(rd_q_reg.h);
        p_rgt = rd_q_reg.x + ext_wh(rd_q_reg.w);
        nbox  = content_reg;
        hit   = 1'b1;
        d     = '0;
        if (fw && (rd_q_reg.y <= content_reg.y + sl)) begin
            d      = c_bot - o_bot;
            nbox.h = d[WH_BITS-1:0];
            nbox.y = o_bot;
        end else if (fw && (p_bot >= c_bot - sl)) begin
            d      = ov_reg.b.y - content_reg.y;
            nbox.h = d[WH_BITS-1:0];
        end else if (fh && (rd_q_reg.x <= content_reg.x + sl)) begin
            d      = c_rgt - o_rgt;
            nbox.w = d[WH_BITS-1:0];
            nbox.x = o_rgt;
        end else if (fh && (p_rgt >= c_rgt - sl)) begin
            d      = ov_reg.b.x - content_reg.x;
            nbox.w = d[WH_BITS-1:0];
        end else begin
            hit = 1'b0;
        end
        upd = hit && (nbox.w != '0) && (nbox.h != '0) && (nbox != content_reg);
    end

    // ----------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && s_set_end) state_next = ST_INIT;
            ST_INIT: state_next = (cnt_reg == '0) ? ST_EST : ST_RD;
            ST_RD:   state_next = ST_OV;
            ST_OV:   state_next = ST_DEC;
            ST_DEC: begin
                if (!idx_last)                state_next = ST_RD;
                else if (changed_reg || upd)  state_next = ST_RD;
                else                          state_next = ST_EST;
            end
            ST_EST:  state_next = (cnt_reg == '0) ? ST_FIN : ST_ERD;
            ST_ERD:  state_next = ST_EOV;
            ST_EOV:  state_next = ST_ECHK;
            ST_ECHK: begin
                if (!ov_reg.ne || out_free) state_next = idx_last ? ST_FIN : ST_ERD;
            end
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slack_reg   <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            ovf_reg     <= 1'b0;
            changed_reg <= 1'b0;
            frame_reg   <= '0;
            window_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) slack_reg <= cfg_wr_data;
            if (accept) begin
                if (s_func == FUNC_FRAME)  frame_reg  <= in_box;
                if (s_func == FUNC_WINDOW) window_reg <= in_box;
                if (s_func == FUNC_PIECE) begin
                    if (cnt_reg < CW'(MAX_PIECES)) cnt_reg <= cnt_reg + CW'(1);
                    else                           ovf_reg <= 1'b1;
                end
            end
            case (state_reg)
                ST_INIT: begin
                    idx_reg     <= '0;
                    changed_reg <= 1'b0;
                end
                ST_DEC: begin
                    if (!idx_last) begin
                        idx_reg <= idx_reg + IDX_W'(1);
                        if (upd) changed_reg <= 1'b1;
                    end else begin
                        idx_reg     <= '0;
                        changed_reg <= 1'b0;
                    end
                end
                ST_EST: idx_reg <= '0;
                ST_ECHK: begin
                    if ((!ov_reg.ne || out_free) && !idx_last)
                        idx_reg <= idx_reg + IDX_W'(1);
                end
                ST_FIN: begin
                    if (out_free) begin
                        frame_reg  <= '0;
                        window_reg <= '0;
                        cnt_reg    <= '0;
                        ovf_reg    <= 1'b0;
                    end
                end
                default: ;
            endcase
            if (push || fin_load) m_valid_reg <= 1'b1;
            else if (m_ready)     m_valid_reg <= 1'b0;
        end
    end

    // piece memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (accept && (s_func == FUNC_PIECE) && (cnt_reg < CW'(MAX_PIECES)))
            piece_mem[cnt_reg[IDX_W-1:0]] <= in_box;
        if (state_reg == ST_RD || state_reg == ST_ERD)
            rd_q_reg <= piece_mem[idx_reg];
    end

    // datapath registers, no reset
    logic signed [SW-1:0] rel_x, rel_y;
    assign rel_x = ov_reg.b.x - content_reg.x;
    assign rel_y = ov_reg.b.y - content_reg.y;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OV || state_reg == ST_EOV) ov_reg <= ov_c;
        if (state_reg == ST_INIT) content_reg <= ov_c.ne ? ov_c.b : frame_reg;
        if (state_reg == ST_DEC && upd) content_reg <= nbox;
        if (state_reg == ST_EST) begin
            pend_kind_reg <= KIND_CONTENT;
            pend_x_reg    <= content_reg.x[COORD_BITS-1:0];
            pend_y_reg    <= content_reg.y[COORD_BITS-1:0];
            pend_w_reg    <= content_reg.w;
            pend_h_reg    <= content_reg.h;
        end
        if (push || fin_load) begin
            out_kind_reg <= pend_kind_reg;
            out_x_reg    <= pend_x_reg;
            out_y_reg    <= pend_y_reg;
            out_w_reg    <= pend_w_reg;
            out_h_reg    <= pend_h_reg;
            out_last_reg <= fin_load;
            out_pd_reg   <= ovf_reg;
        end
        if (push) begin
            pend_kind_reg <= KIND_OCCLUDER;
            pend_x_reg    <= rel_x[COORD_BITS-1:0];
            pend_y_reg    <= rel_y[COORD_BITS-1:0];
            pend_w_reg    <= ov_reg.b.w;
            pend_h_reg    <= ov_reg.b.h;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_kind       = out_kind_reg;
    assign m_out_x          = out_x_reg;
    assign m_out_y          = out_y_reg;
    assign m_out_width      = out_w_reg;
    assign m_out_height     = out_h_reg;
    assign m_out_last       = out_last_reg;
    assign m_pieces_dropped = out_pd_reg;

    // ---------------------------------------------------------- assertions
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_PIECES))
        else $error("piece count beyond store depth");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD || state_reg == ST_ERD) |-> (CW'(idx_reg) < cnt_reg))
        else $error("piece read past fill count");

    a_start_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT) |-> $past(accept && s_set_end))
        else $error("trim started without set_end beat");

    a_set_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_load |=> (cnt_reg == '0) && !ovf_reg && m_valid && m_out_last)
        else $error("set state not cleared after final beat");

endmodule
